FILE: rtl/ps2mct_pkg.sv
package ps2mct_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CUR_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd1080;

  localparam logic EV_MOVE   = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  typedef struct packed {
    logic [2:0] btn;
    logic       sign_x;
    logic       sign_y;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  typedef struct packed {
    logic             kind;
    logic [CUR_W-1:0] x;
    logic [CUR_W-1:0] y;
    logic [2:0]       mask;
    logic [1:0]       index;
    logic             down;
    logic             last;
  } ev_t;

endpackage

FILE: rtl/ps2mct_fifo.sv
module ps2mct_fifo #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/ps2mct_front.sv
module ps2mct_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         data_i,
  output logic               full_o,
  output ps2mct_pkg::pkt_t   pkt_o,
  output logic               pkt_push_o,
  input  logic               pkt_full_i
);
  import ps2mct_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_DX  = 3'b010,
    PH_DY  = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] dx_q, dx_d;
  logic       accept;

  assign full_o = pkt_full_i;
  assign accept = push_i && !pkt_full_i;

  always_comb begin
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    dx_d       = dx_q;
    pkt_push_o = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_DX: begin
          dx_d    = data_i;
          phase_d = PH_DY;
        end
        PH_DY: begin
          pkt_push_o = 1'b1;
          phase_d    = PH_HDR;
        end
        default: begin
          if (data_i[3]) begin
            hdr_d   = data_i;
            phase_d = PH_DX;
          end else begin
            phase_d = PH_HDR;
          end
        end
      endcase
    end
  end

  assign pkt_o.btn    = hdr_q[2:0];
  assign pkt_o.sign_x = hdr_q[4];
  assign pkt_o.sign_y = hdr_q[5];
  assign pkt_o.dx     = dx_q;
  assign pkt_o.dy     = data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      hdr_q   <= 8'd0;
      dx_q    <= 8'd0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
    end
  end

endmodule

FILE: rtl/ps2mct_back.sv
module ps2mct_back #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ps2mct_pkg::CFG_W-1:0]     cfg_data_i,
  input  ps2mct_pkg::pkt_t                 pkt_i,
  input  logic                             pkt_valid_i,
  output logic                             pkt_pop_o,
  output ps2mct_pkg::ev_t                  ev_o,
  output logic                             ev_push_o,
  input  logic                             ev_full_i
);
  import ps2mct_pkg::*;

  localparam int unsigned CW     = COORD_BITS;
  localparam int unsigned VW     = CW + 2;
  localparam int unsigned LW     = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned CMAX_I = (1 << CW) - 1;
  localparam int unsigned RX_I   = (RESET_WIDTH / 2 > CMAX_I) ? CMAX_I : RESET_WIDTH / 2;
  localparam int unsigned RY_I   = (RESET_HEIGHT / 2 > CMAX_I) ? CMAX_I : RESET_HEIGHT / 2;
  localparam logic [LW-1:0] CMAX_L = LW'(CMAX_I);
  localparam logic [CW-1:0] POS_X_RST = CW'(RX_I);
  localparam logic [CW-1:0] POS_Y_RST = CW'(RY_I);

  function automatic logic [CW-1:0] lim_of(input logic [CFG_W-1:0] size);
    logic [CFG_W-1:0] s;
    logic [LW-1:0]    sm1;
    s   = (size == '0) ? CFG_W'(1) : size;
    sm1 = LW'(s - CFG_W'(1));
    if (sm1 > CMAX_L) begin
      return CMAX_L[CW-1:0];
    end
    return sm1[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] move_axis(input logic [CW-1:0] pos,
                                              input logic [7:0]    delta,
                                              input logic          neg,
                                              input logic [CW-1:0] lim);
    logic [VW-1:0] v;
    v = VW'(pos) + VW'(delta) - (neg ? VW'(256) : VW'(0));
    if (v[VW-1]) begin
      return '0;
    end else if (v > VW'(lim)) begin
      return lim;
    end
    return v[CW-1:0];
  endfunction

  logic [CW-1:0] lim_x_q, lim_y_q;
  logic [CW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [CW-1:0] nx, ny;
  logic [2:0]    held_q, held_d;
  logic [2:0]    old_btn_q, old_btn_d;
  logic [2:0]    new_btn_q, new_btn_d;
  logic [3:0]    pend_q, pend_d;
  logic [3:0]    rest;
  logic [1:0]    sel;
  logic [1:0]    bidx;
  logic          found;
  logic          is_move;
  logic          load;
  logic [CW+CUR_W-1:0] xe, ye;

  always_comb begin
    sel   = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && pend_q[i]) begin
        sel   = 2'(i);
        found = 1'b1;
      end
    end
  end

  assign rest      = pend_q & ~(4'b0001 << sel);
  assign is_move   = (sel == 2'd0);
  assign bidx      = sel - 2'd1;
  assign ev_push_o = found && !ev_full_i;
  assign load      = pkt_valid_i && (!found || (ev_push_o && rest == 4'd0));
  assign pkt_pop_o = load;

  assign nx = move_axis(pos_x_q, pkt_i.dx, pkt_i.sign_x, lim_x_q);
  assign ny = move_axis(pos_y_q, pkt_i.dy, pkt_i.sign_y, lim_y_q);

  assign xe = {{CUR_W{1'b0}}, pos_x_q};
  assign ye = {{CUR_W{1'b0}}, pos_y_q};

  assign ev_o.kind  = is_move ? EV_MOVE : EV_BUTTON;
  assign ev_o.x     = xe[CUR_W-1:0];
  assign ev_o.y     = ye[CUR_W-1:0];
  assign ev_o.mask  = is_move ? old_btn_q : 3'd0;
  assign ev_o.index = is_move ? 2'd0 : bidx;
  assign ev_o.down  = is_move ? 1'b0 : |(new_btn_q & (3'b001 << bidx));
  assign ev_o.last  = (rest == 4'd0);

  always_comb begin
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    held_d    = held_q;
    old_btn_d = old_btn_q;
    new_btn_d = new_btn_q;
    pend_d    = ev_push_o ? rest : pend_q;
    if (load) begin
      pos_x_d   = nx;
      pos_y_d   = ny;
      held_d    = pkt_i.btn;
      old_btn_d = held_q;
      new_btn_d = pkt_i.btn;
      pend_d    = {pkt_i.btn ^ held_q, (nx != pos_x_q) || (ny != pos_y_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_x_q <= lim_of(RESET_WIDTH);
      lim_y_q <= lim_of(RESET_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH:  lim_x_q <= lim_of(cfg_data_i);
        REG_SCREEN_HEIGHT: lim_y_q <= lim_of(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= POS_X_RST;
      pos_y_q   <= POS_Y_RST;
      held_q    <= 3'd0;
      old_btn_q <= 3'd0;
      new_btn_q <= 3'd0;
      pend_q    <= 4'd0;
    end else begin
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      held_q    <= held_d;
      old_btn_q <= old_btn_d;
      new_btn_q <= new_btn_d;
      pend_q    <= pend_d;
    end
  end

endmodule

FILE: rtl/ps2_mouse_cursor_tracker.sv
// A byte is accepted in every cycle while full is low; full rises only when the
// packet queue between the byte assembler and the event sequencer holds two packets.
// A packet's events pass the pending bits and the event queue to the result
// ports; the sequencer issues one event per cycle while the event queue has room.
// Reset clears all queues, waits for a header byte, centers the cursor on a
// 1920 by 1080 screen and releases all buttons.
module ps2_mouse_cursor_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ps2mct_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       data_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic                             event_kind_o,
  output logic [ps2mct_pkg::CUR_W-1:0]     cursor_x_o,
  output logic [ps2mct_pkg::CUR_W-1:0]     cursor_y_o,
  output logic [2:0]                       button_mask_o,
  output logic [1:0]                       button_index_o,
  output logic                             button_down_o,
  output logic                             last_o
);
  import ps2mct_pkg::*;

  pkt_t pkt_in, pkt_out;
  ev_t  ev_in, ev_out;
  logic pkt_push, pkt_full, pkt_empty, pkt_pop;
  logic ev_push, ev_full;

  ps2mct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (data_byte_i),
    .full_o     (full),
    .pkt_o      (pkt_in),
    .pkt_push_o (pkt_push),
    .pkt_full_i (pkt_full)
  );

  ps2mct_fifo #(
    .WIDTH ($bits(pkt_t))
  ) u_pkt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .wdata_i (pkt_in),
    .full_o  (pkt_full),
    .pop_i   (pkt_pop),
    .rdata_o (pkt_out),
    .empty_o (pkt_empty)
  );

  ps2mct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pkt_i       (pkt_out),
    .pkt_valid_i (!pkt_empty),
    .pkt_pop_o   (pkt_pop),
    .ev_o        (ev_in),
    .ev_push_o   (ev_push),
    .ev_full_i   (ev_full)
  );

  ps2mct_fifo #(
    .WIDTH ($bits(ev_t))
  ) u_ev_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .wdata_i (ev_in),
    .full_o  (ev_full),
    .pop_i   (pop),
    .rdata_o (ev_out),
    .empty_o (empty)
  );

  assign event_kind_o   = ev_out.kind;
  assign cursor_x_o     = ev_out.x;
  assign cursor_y_o     = ev_out.y;
  assign button_mask_o  = ev_out.mask;
  assign button_index_o = ev_out.index;
  assign button_down_o  = ev_out.down;
  assign last_o         = ev_out.last;

endmodule

FILE: tb/ps2_mouse_cursor_tracker_tb.sv
module ps2_mouse_cursor_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mct_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int COORD_MAX     = (1 << CUR_W) - 1;

  typedef enum logic [1:0] {PH_HDR, PH_DX, PH_DY} byte_phase_e;
  typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_e;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = REG_SCREEN_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 push       = 1'b0;
  logic [7:0]           data_byte_i = '0;
  logic                 pop        = 1'b0;
  logic                 full;
  logic                 empty;
  logic                 event_kind_o;
  logic [CUR_W-1:0]     cursor_x_o;
  logic [CUR_W-1:0]     cursor_y_o;
  logic [2:0]           button_mask_o;
  logic [1:0]           button_index_o;
  logic                 button_down_o;
  logic                 last_o;

  logic [7:0] mouse_bytes[$];
  ev_t        expected_events[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic [2:0] gen_buttons = '0;

  byte_phase_e      track_phase = PH_HDR;
  logic [7:0]       track_hdr = '0;
  logic [7:0]       track_dx = '0;
  logic [CUR_W-1:0] track_x = CUR_W'(RESET_WIDTH / 2);
  logic [CUR_W-1:0] track_y = CUR_W'(RESET_HEIGHT / 2);
  logic [2:0]       track_buttons = '0;
  logic [CFG_W-1:0] track_width = RESET_WIDTH;
  logic [CFG_W-1:0] track_height = RESET_HEIGHT;

  ps2_mouse_cursor_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .cursor_x_o     (cursor_x_o),
    .cursor_y_o     (cursor_y_o),
    .button_mask_o  (button_mask_o),
    .button_index_o (button_index_o),
    .button_down_o  (button_down_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CUR_W-1:0] step_axis(logic [CUR_W-1:0] pos, logic [7:0] delta,
                                                  logic negative, logic [CFG_W-1:0] size);
    int v;
    int lim;
    v   = int'(pos) + int'(delta) - (negative ? 256 : 0);
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > COORD_MAX) lim = COORD_MAX;
    if (v < 0) return '0;
    if (v > lim) return lim[CUR_W-1:0];
    return v[CUR_W-1:0];
  endfunction

  task automatic track_byte(input logic [7:0] b);
    logic [CUR_W-1:0] old_x;
    logic [CUR_W-1:0] old_y;
    logic [2:0]       old_buttons;
    logic [2:0]       changed;
    ev_t              ev;
    int               first;
    first = expected_events.size();
    case (track_phase)
      PH_DX: begin
        track_dx = b;
        track_phase = PH_DY;
      end
      PH_DY: begin
        track_phase = PH_HDR;
        old_x = track_x;
        old_y = track_y;
        old_buttons = track_buttons;
        track_x = step_axis(track_x, track_dx, track_hdr[4], track_width);
        track_y = step_axis(track_y, b, track_hdr[5], track_height);
        track_buttons = track_hdr[2:0];
        ev = '0;
        ev.x = track_x;
        ev.y = track_y;
        if (track_x != old_x || track_y != old_y) begin
          ev.kind = EV_MOVE;
          ev.mask = old_buttons;
          expected_events.push_back(ev);
        end
        changed = track_buttons ^ old_buttons;
        ev.kind = EV_BUTTON;
        ev.mask = '0;
        for (int i = 0; i < 3; i++) begin
          if (changed[i]) begin
            ev.index = 2'(i);
            ev.down = track_buttons[i];
            expected_events.push_back(ev);
          end
        end
        if (expected_events.size() > first) begin
          expected_events[expected_events.size() - 1].last = 1'b1;
        end
      end
      default: begin
        if (b[3]) begin
          track_hdr = b;
          track_phase = PH_DX;
        end else begin
          track_phase = PH_HDR;
        end
      end
    endcase
  endtask

  function automatic void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) track_byte(data_byte_i);
      if (!push || !full) begin
        if (mouse_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          data_byte_i <= mouse_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result beat: kind %0d x %0d y %0d",
                 event_kind_o, cursor_x_o, cursor_y_o);
          mismatches++;
        end else begin
          ev_t ev;
          ev = expected_events.pop_front();
          check_field("event_kind", ev.kind, event_kind_o);
          check_field("cursor_x", ev.x, cursor_x_o);
          check_field("cursor_y", ev.y, cursor_y_o);
          check_field("button_mask", ev.mask, button_mask_o);
          check_field("button_index", ev.index, button_index_o);
          check_field("button_down", ev.down, button_down_o);
          check_field("last", ev.last, last_o);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_SCREEN_WIDTH: track_width = value;
      default: track_height = value;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_packet(input drift_e drift);
    logic [7:0] dx;
    logic [7:0] dy;
    logic       sx;
    logic       sy;
    logic [2:0] buttons;
    dx = 8'($urandom);
    dy = 8'($urandom);
    sx = 1'($urandom);
    sy = 1'($urandom);
    buttons = ($urandom_range(2) == 0) ? gen_buttons : 3'($urandom);
    if (drift == DRIFT_UP) begin
      sx = ($urandom_range(9) == 0);
      sy = ($urandom_range(9) == 0);
    end else if (drift == DRIFT_DOWN) begin
      sx = ($urandom_range(9) != 0);
      sy = ($urandom_range(9) != 0);
    end
    if ($urandom_range(7) == 0) begin
      dx = '0;
      dy = '0;
      sx = 1'b0;
      sy = 1'b0;
    end
    gen_buttons = buttons;
    mouse_bytes.push_back({2'($urandom), sy, sx, 1'b1, buttons});
    mouse_bytes.push_back(dx);
    mouse_bytes.push_back(dy);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (mouse_bytes.size() != 0 || push || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int num_bytes, input drift_e drift,
                           input int sender_idle, input int receiver_idle);
    int target;
    @(negedge clk_i);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    target = mouse_bytes.size() + num_bytes;
    while (mouse_bytes.size() < target) begin
      if ($urandom_range(9) == 0) begin
        mouse_bytes.push_back(($urandom_range(1) == 0) ? 8'($urandom) & 8'hF7 : 8'($urandom));
      end else begin
        add_packet(drift);
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    send_idle_pct = 30;
    recv_idle_pct = 46;
    mouse_bytes = '{8'h00, 8'hF7,
                    8'h08, 8'h00, 8'h00,
                    8'hC9, 8'h00, 8'h00,
                    8'h0F, 8'hFF, 8'hFF,
                    8'h3F, 8'h00, 8'h00,
                    8'h38, 8'h00, 8'h00,
                    8'h28, 8'h00, 8'h00,
                    8'h28, 8'h00, 8'h00};
    gen_buttons = 3'b000;
    run_phase(60, DRIFT_NONE, 30, 46);

    write_reg(REG_SCREEN_WIDTH, '0);
    write_reg(REG_SCREEN_HEIGHT, 13'd1);
    run_phase(30, DRIFT_NONE, 30, 46);

    write_reg(REG_SCREEN_WIDTH, 13'h1FFF);
    write_reg(REG_SCREEN_HEIGHT, 13'd4096);
    run_phase(60, DRIFT_UP, 46, 30);

    write_reg(REG_SCREEN_WIDTH, 13'd640);
    write_reg(REG_SCREEN_HEIGHT, 13'd480);
    run_phase(25, DRIFT_NONE, 46, 30);
    run_phase(25, DRIFT_DOWN, 46, 30);

    write_reg(REG_SCREEN_WIDTH, CFG_W'($urandom_range(4096, 1)));
    write_reg(REG_SCREEN_HEIGHT, CFG_W'($urandom_range(4096, 1)));
    run_phase(30, DRIFT_DOWN, 0, 0);
    run_phase(30, DRIFT_NONE, 0, 0);

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
